[rtl/core/kwlex_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kwlex_pkg
// Shared types, token kinds and byte classes of the keyword token lexer.
// ----------------------------------------------------------------------------
package kwlex_pkg;

	// Default values for the top-level parameters.
	localparam int DEF_MAX_LEXEME  = 80;
	localparam int DEF_TAB_STOP    = 8;
	localparam int DEF_QUEUE_DEPTH = 2;

	localparam int POS_W   = 16;
	localparam int NUM_W   = 31;
	localparam int LEN_OUT = 7;

	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [NUM_W-1:0] NUM_MAX = '1;

	// Token kinds.
	localparam logic [3:0] K_ID     = 4'd0;
	localparam logic [3:0] K_NUM    = 4'd1;
	localparam logic [3:0] K_IF     = 4'd2;
	localparam logic [3:0] K_INT    = 4'd3;
	localparam logic [3:0] K_FLOAT  = 4'd4;
	localparam logic [3:0] K_ELSE   = 4'd5;
	localparam logic [3:0] K_ASSIGN = 4'd6;
	localparam logic [3:0] K_EQ     = 4'd7;
	localparam logic [3:0] K_LPAR   = 4'd8;
	localparam logic [3:0] K_RPAR   = 4'd9;
	localparam logic [3:0] K_LBRACE = 4'd10;
	localparam logic [3:0] K_RBRACE = 4'd11;
	localparam logic [3:0] K_COMMA  = 4'd12;
	localparam logic [3:0] K_SCOLON = 4'd13;
	localparam logic [3:0] K_EOF    = 4'd14;
	localparam logic [3:0] K_ERROR  = 4'd15;

	// Byte classes assigned by the front end.
	localparam logic [3:0] CLS_NUL    = 4'd0;
	localparam logic [3:0] CLS_WS     = 4'd1;
	localparam logic [3:0] CLS_DIGIT  = 4'd2;
	localparam logic [3:0] CLS_LETTER = 4'd3;
	localparam logic [3:0] CLS_EQUAL  = 4'd4;
	localparam logic [3:0] CLS_SLASH  = 4'd5;
	localparam logic [3:0] CLS_STAR   = 4'd6;
	localparam logic [3:0] CLS_PUNCT  = 4'd7;
	localparam logic [3:0] CLS_OTHER  = 4'd8;

	// One classified byte with its source position before and after it.
	typedef struct packed {
		logic [7:0]       ch;
		logic [3:0]       cls;
		logic [3:0]       punct_kind;
		logic [POS_W-1:0] line_pre;
		logic [POS_W-1:0] col_pre;
		logic [POS_W-1:0] line_post;
		logic [POS_W-1:0] col_post;
	} kwlex_item_t;

	// One token as it leaves the block.
	typedef struct packed {
		logic [3:0]         kind;
		logic [NUM_W-1:0]   num_value;
		logic [LEN_OUT-1:0] lexeme_length;
		logic [7:0]         bad_char;
		logic [POS_W-1:0]   line_no;
		logic [POS_W-1:0]   column_no;
		logic               last;
	} kwlex_result_t;

	// Tokens handed together from the back end to the output queue.
	typedef struct packed {
		logic [1:0]    n;
		kwlex_result_t r0;
		kwlex_result_t r1;
	} kwlex_push_t;

endpackage
`default_nettype wire

[rtl/core/keyword_token_lexer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_token_lexer
// Streaming lexer: one source byte per item in, tokens out.
// ----------------------------------------------------------------------------
// The block takes one source byte per item (byte 0 marks end of input) and
// returns the tokens it completes: identifiers with their length, the
// keywords if, int, float and else, saturating decimal numbers, = and ==,
// punctuation, end of input and invalid-byte errors, each stamped with the
// line and column. A token that needs a following byte to end is stamped with
// the position before that byte; all others with the position after it. One
// byte causes zero, one or two tokens, and the last token of a byte has last
// set. The front end classifies each byte and tracks the position, a short
// queue decouples it from the back end, which runs the automaton and writes
// into a two-entry output queue. The block accepts one byte per cycle as long
// as each byte yields at most one token and the consumer takes them; a byte
// yielding two tokens hands them out one after the other on the single output
// port. With no older work queued, the byte completing a token is registered
// in the byte queue and the token in the output queue before the token is
// offered at the output.
// ----------------------------------------------------------------------------
module keyword_token_lexer import kwlex_pkg::*; #(
	parameter int MAX_LEXEME  = DEF_MAX_LEXEME,
	parameter int TAB_STOP    = DEF_TAB_STOP,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           ch,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [3:0]                kind,
	output logic [NUM_W-1:0]          num_value,
	output logic [LEN_OUT-1:0]        lexeme_length,
	output logic [7:0]                bad_char,
	output logic [POS_W-1:0]          line_no,
	output logic [POS_W-1:0]          column_no,
	output logic                      last
);

	kwlex_item_t   fe_item, be_item;
	kwlex_push_t   be_push;
	kwlex_result_t oq_head;
	logic          accept, be_valid, be_pop;
	logic [1:0]    oq_free;

	// A byte enters whenever the queue has room.
	assign accept = in_valid && in_ready;

	kwlex_front #(
		.TAB_STOP (TAB_STOP)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.ch     (ch),
		.accept (accept),
		.item   (fe_item)
	);

	kwlex_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.wr_item   (fe_item),
		.pop       (be_pop),
		.rd_item   (be_item),
		.not_empty (be_valid),
		.not_full  (in_ready)
	);

	// The back end consumes a byte only if all of its tokens fit.
	kwlex_back #(
		.MAX_LEXEME (MAX_LEXEME)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (be_item),
		.item_valid (be_valid),
		.free       (oq_free),
		.pop        (be_pop),
		.push       (be_push)
	);

	kwlex_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (be_push),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.head      (oq_head),
		.free      (oq_free)
	);

	assign kind          = oq_head.kind;
	assign num_value     = oq_head.num_value;
	assign lexeme_length = oq_head.lexeme_length;
	assign bad_char      = oq_head.bad_char;
	assign line_no       = oq_head.line_no;
	assign column_no     = oq_head.column_no;
	assign last          = oq_head.last;

endmodule
`default_nettype wire

[rtl/core/kwlex_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kwlex_front
// Accepts source bytes, classifies them and tracks line and column.
// ----------------------------------------------------------------------------
module kwlex_front import kwlex_pkg::*; #(
	parameter int TAB_STOP = DEF_TAB_STOP
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  ch,
	input  wire logic        accept,
	output kwlex_item_t      item
);

	localparam int PH_W = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
	localparam logic [PH_W-1:0] PH_LAST = PH_W'(TAB_STOP - 1);
	localparam logic [PH_W-1:0] PH_SAT  = PH_W'(65535 % TAB_STOP);

	logic [POS_W-1:0] line_q, col_q, line_n, col_n;
	// Column modulo the tab stop, kept alongside the column.
	logic [PH_W-1:0]  phase_q, phase_n;
	logic [POS_W:0]   tab_col;

	always_comb begin
		line_n  = line_q;
		col_n   = col_q;
		phase_n = phase_q;
		tab_col = {1'b0, col_q} + (POS_W+1)'(TAB_STOP) - (POS_W+1)'(phase_q);
		if (ch == 8'h0a) begin
			if (line_q != POS_MAX) line_n = line_q + 1'b1;
			col_n   = '0;
			phase_n = '0;
		end else if (ch == 8'h09) begin
			if (tab_col[POS_W]) begin
				col_n   = POS_MAX;
				phase_n = PH_SAT;
			end else begin
				col_n   = tab_col[POS_W-1:0];
				phase_n = '0;
			end
		end else if (col_q != POS_MAX) begin
			col_n   = col_q + 1'b1;
			phase_n = (phase_q == PH_LAST) ? '0 : phase_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q  <= POS_W'(1);
			col_q   <= '0;
			phase_q <= '0;
		end else if (accept) begin
			line_q  <= line_n;
			col_q   <= col_n;
			phase_q <= phase_n;
		end
	end

	always_comb begin
		item.ch         = ch;
		item.line_pre   = line_q;
		item.col_pre    = col_q;
		item.line_post  = line_n;
		item.col_post   = col_n;
		item.punct_kind = K_ERROR;
		if (ch == 8'h00) begin
			item.cls = CLS_NUL;
		end else if (ch == " " || ch == 8'h09 || ch == 8'h0a) begin
			item.cls = CLS_WS;
		end else if (ch >= "0" && ch <= "9") begin
			item.cls = CLS_DIGIT;
		end else if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")) begin
			item.cls = CLS_LETTER;
		end else if (ch == "=") begin
			item.cls = CLS_EQUAL;
		end else if (ch == "/") begin
			item.cls = CLS_SLASH;
		end else if (ch == "*") begin
			item.cls = CLS_STAR;
		end else begin
			item.cls = CLS_PUNCT;
			case (ch)
				"(":     item.punct_kind = K_LPAR;
				")":     item.punct_kind = K_RPAR;
				"{":     item.punct_kind = K_LBRACE;
				"}":     item.punct_kind = K_RBRACE;
				",":     item.punct_kind = K_COMMA;
				";":     item.punct_kind = K_SCOLON;
				default: item.cls = CLS_OTHER;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/kwlex_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kwlex_fifo
// Short queue of classified bytes between the front end and the back end.
// ----------------------------------------------------------------------------
module kwlex_fifo import kwlex_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire kwlex_item_t wr_item,
	input  wire logic  pop,
	output kwlex_item_t rd_item,
	output logic       not_empty,
	output logic       not_full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	kwlex_item_t      store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign not_empty = (cnt_q != '0);
	assign not_full  = (cnt_q != CNT_W'(DEPTH));
	assign rd_item   = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) store_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/kwlex_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kwlex_back
// Lexer automaton: consumes classified bytes and produces up to two tokens.
// ----------------------------------------------------------------------------
module kwlex_back import kwlex_pkg::*; #(
	parameter int MAX_LEXEME = DEF_MAX_LEXEME
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire kwlex_item_t item,
	input  wire logic  item_valid,
	input  wire logic [1:0] free,
	output logic       pop,
	output kwlex_push_t push
);

	localparam int LEN_W = ($clog2(MAX_LEXEME) > LEN_OUT) ? $clog2(MAX_LEXEME) : LEN_OUT;
	localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_LEXEME - 1);

	localparam logic [4:0] S_START   = 5'd0;
	localparam logic [4:0] S_ID      = 5'd1;
	localparam logic [4:0] S_NUM     = 5'd2;
	localparam logic [4:0] S_I       = 5'd3;
	localparam logic [4:0] S_IF      = 5'd4;
	localparam logic [4:0] S_IN      = 5'd5;
	localparam logic [4:0] S_INT     = 5'd6;
	localparam logic [4:0] S_F       = 5'd7;
	localparam logic [4:0] S_FL      = 5'd8;
	localparam logic [4:0] S_FLO     = 5'd9;
	localparam logic [4:0] S_FLOA    = 5'd10;
	localparam logic [4:0] S_FLOAT   = 5'd11;
	localparam logic [4:0] S_E       = 5'd12;
	localparam logic [4:0] S_EL      = 5'd13;
	localparam logic [4:0] S_ELS     = 5'd14;
	localparam logic [4:0] S_ELSE    = 5'd15;
	localparam logic [4:0] S_ASSIGN  = 5'd16;
	localparam logic [4:0] S_SLASH   = 5'd17;
	localparam logic [4:0] S_COMMENT = 5'd18;
	localparam logic [4:0] S_CSTAR   = 5'd19;

	function automatic logic [4:0] word_next(input logic [4:0] s, input logic [7:0] c);
		logic [4:0] r;
		r = S_ID;
		unique case (s)
			S_I:     r = (c == "f") ? S_IF : ((c == "n") ? S_IN : S_ID);
			S_IN:    r = (c == "t") ? S_INT : S_ID;
			S_F:     r = (c == "l") ? S_FL : S_ID;
			S_FL:    r = (c == "o") ? S_FLO : S_ID;
			S_FLO:   r = (c == "a") ? S_FLOA : S_ID;
			S_FLOA:  r = (c == "t") ? S_FLOAT : S_ID;
			S_E:     r = (c == "l") ? S_EL : S_ID;
			S_EL:    r = (c == "s") ? S_ELS : S_ID;
			S_ELS:   r = (c == "e") ? S_ELSE : S_ID;
			default: r = S_ID;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] word_kind(input logic [4:0] s);
		logic [3:0] k;
		k = K_ID;
		unique case (s)
			S_IF:    k = K_IF;
			S_INT:   k = K_INT;
			S_FLOAT: k = K_FLOAT;
			S_ELSE:  k = K_ELSE;
			default: k = K_ID;
		endcase
		return k;
	endfunction

	function automatic kwlex_result_t mk(
		input logic [3:0]         kind,
		input logic [NUM_W-1:0]   val,
		input logic [LEN_OUT-1:0] len,
		input logic [7:0]         bad,
		input logic [POS_W-1:0]   line,
		input logic [POS_W-1:0]   col
	);
		kwlex_result_t r;
		r.kind          = kind;
		r.num_value     = val;
		r.lexeme_length = len;
		r.bad_char      = bad;
		r.line_no       = line;
		r.column_no     = col;
		r.last          = 1'b0;
		return r;
	endfunction

	logic [4:0]       state_q, state_n;
	logic [NUM_W-1:0] acc_q, acc_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic [NUM_W+3:0] acc_x10;
	logic [1:0]       n;
	logic             fresh, emit_f;
	kwlex_result_t    r0, r1, e;

	always_comb begin
		state_n = state_q;
		acc_n   = acc_q;
		len_n   = len_q;
		n       = 2'd0;
		r0      = '0;
		r1      = '0;
		e       = '0;
		fresh   = 1'b0;
		emit_f  = 1'b0;
		acc_x10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (NUM_W+4)'(item.ch[3:0]);

		unique case (state_q) inside
			S_ID, S_I, S_IF, S_IN, S_INT, S_F, S_FL, S_FLO, S_FLOA, S_FLOAT,
			S_E, S_EL, S_ELS, S_ELSE: begin
				if (item.cls == CLS_LETTER || item.cls == CLS_DIGIT) begin
					state_n = word_next(state_q, item.ch);
					if (len_q < LEN_SAT) len_n = len_q + 1'b1;
				end else begin
					r0    = mk(word_kind(state_q), '0, len_q[LEN_OUT-1:0], 8'h00,
						item.line_pre, item.col_pre);
					n     = 2'd1;
					fresh = 1'b1;
				end
			end
			S_NUM: begin
				if (item.cls == CLS_DIGIT) begin
					acc_n = (acc_x10 > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : acc_x10[NUM_W-1:0];
				end else begin
					r0    = mk(K_NUM, acc_q, '0, 8'h00, item.line_pre, item.col_pre);
					n     = 2'd1;
					fresh = 1'b1;
				end
			end
			S_ASSIGN: begin
				if (item.cls == CLS_EQUAL) begin
					r0      = mk(K_EQ, '0, '0, 8'h00, item.line_post, item.col_post);
					n       = 2'd1;
					state_n = S_START;
				end else begin
					r0    = mk(K_ASSIGN, '0, '0, 8'h00, item.line_pre, item.col_pre);
					n     = 2'd1;
					fresh = 1'b1;
				end
			end
			S_SLASH: begin
				if (item.cls == CLS_STAR) begin
					state_n = S_COMMENT;
				end else begin
					r0    = mk(K_ERROR, '0, '0, "/", item.line_pre, item.col_pre);
					n     = 2'd1;
					fresh = 1'b1;
				end
			end
			S_COMMENT, S_CSTAR: begin
				if (item.cls == CLS_NUL) begin
					r0      = mk(K_EOF, '0, '0, 8'h00, item.line_post, item.col_post);
					n       = 2'd1;
					state_n = S_START;
				end else if (item.cls == CLS_STAR) begin
					state_n = S_CSTAR;
				end else if (state_q == S_CSTAR && item.cls == CLS_SLASH) begin
					state_n = S_START;
				end else begin
					state_n = S_COMMENT;
				end
			end
			default: fresh = 1'b1;
		endcase

		// The byte is handled from the start state.
		if (fresh) begin
			state_n = S_START;
			case (item.cls)
				CLS_NUL: begin
					e      = mk(K_EOF, '0, '0, 8'h00, item.line_post, item.col_post);
					emit_f = 1'b1;
				end
				CLS_WS: ;
				CLS_DIGIT: begin
					acc_n   = NUM_W'(item.ch[3:0]);
					state_n = S_NUM;
				end
				CLS_LETTER: begin
					len_n   = LEN_W'(1);
					state_n = (item.ch == "i") ? S_I :
						((item.ch == "f") ? S_F : ((item.ch == "e") ? S_E : S_ID));
				end
				CLS_EQUAL: state_n = S_ASSIGN;
				CLS_SLASH: state_n = S_SLASH;
				CLS_PUNCT: begin
					e      = mk(item.punct_kind, '0, '0, 8'h00, item.line_post, item.col_post);
					emit_f = 1'b1;
				end
				default: begin
					e      = mk(K_ERROR, '0, '0, item.ch, item.line_post, item.col_post);
					emit_f = 1'b1;
				end
			endcase
			if (emit_f) begin
				if (n == 2'd0) begin
					r0 = e;
				end else begin
					r1 = e;
				end
				n = n + 2'd1;
			end
		end

		if (n == 2'd1) r0.last = 1'b1;
		if (n == 2'd2) r1.last = 1'b1;
	end

	assign pop    = item_valid && (n <= free);
	assign push.n = pop ? n : 2'd0;
	assign push.r0 = r0;
	assign push.r1 = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_START;
			acc_q   <= '0;
			len_q   <= '0;
		end else if (pop) begin
			state_q <= state_n;
			acc_q   <= acc_n;
			len_q   <= len_n;
		end
	end

endmodule
`default_nettype wire

[rtl/core/kwlex_outq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kwlex_outq
// Two-entry output queue that takes up to two tokens and hands out one.
// ----------------------------------------------------------------------------
module kwlex_outq import kwlex_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire kwlex_push_t push,
	input  wire logic  out_ready,
	output logic       out_valid,
	output kwlex_result_t head,
	output logic [1:0] free
);

	kwlex_result_t e0_q, e1_q, nx0, nx1;
	logic [1:0]    cnt_q, rc;
	logic          pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign head      = e0_q;
	assign free      = 2'd2 - cnt_q + {1'b0, pop};

	always_comb begin
		rc  = cnt_q - {1'b0, pop};
		nx0 = pop ? e1_q : e0_q;
		nx1 = e1_q;
		if (push.n != 2'd0) begin
			if (rc == 2'd0) begin
				nx0 = push.r0;
				nx1 = push.r1;
			end else begin
				nx1 = push.r0;
			end
		end
	end

	always_ff @(posedge clk) begin
		e0_q <= nx0;
		e1_q <= nx1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= rc + push.n;
		end
	end

endmodule
`default_nettype wire
